>>> rtl/sic_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sic_pkg: shared types and constants of the segmentation IoU counter
// Word formats of both channels, request codes, bank request struct and
// output buffer sizing.
// ----------------------------------------------------------------------------
package sic_pkg;

  // Fixed field widths
  localparam int CLASS_W  = 8;
  localparam int SCORE_W  = 16;
  localparam int NCLS_W   = 9;
  localparam int OUT_CNT_W = 32;

  // Label value that marks a pixel as don't-care
  localparam logic [CLASS_W-1:0] IGNORE_LABEL = 8'd255;

  // num_classes after reset
  localparam logic [NCLS_W-1:0] NUM_CLASSES_RST = 9'd21;

  // Output buffer sizing
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_FILL_W = OUT_PTR_W + 1;

  // Request codes; code 3 is unused and dropped
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_t;

  typedef struct packed {
    req_type_t                  req_type;
    logic signed [SCORE_W-1:0]  score;
    logic [CLASS_W-1:0]         channel;
    logic                       last_channel;
    logic [CLASS_W-1:0]         label;
    logic [CLASS_W-1:0]         class_select;
  } in_word_t;

  typedef struct packed {
    logic [CLASS_W-1:0]   class_index;
    logic [OUT_CNT_W-1:0] true_pos;
    logic [OUT_CNT_W-1:0] false_pos;
    logic [OUT_CNT_W-1:0] false_neg;
    logic                 range_error;
  } out_word_t;

  // Per-bank request issued at accept time
  typedef struct packed {
    logic               inc;
    logic [CLASS_W-1:0] addr;
  } bank_req_t;

endpackage
`default_nettype wire

>>> rtl/sic_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sic_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module sic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/sic_counter_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sic_counter_bank: one bank of per-class saturating counters
// RAM-backed read-modify-write. Read issued at accept, increment and
// write-back in the next cycle. Valid bits give zero for entries not written
// since reset or the last clear; a forwarding register covers a read of the
// entry written in the same cycle.
// ----------------------------------------------------------------------------
module sic_counter_bank #(
  parameter int MAX_CLASSES = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clear_i,
  input  wire sic_pkg::bank_req_t     req_i,
  output logic      [COUNT_WIDTH-1:0] count_o
);

  localparam int AW = $clog2(MAX_CLASSES);

  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          s1_addr_r;
  logic                   s1_inc_r;
  logic [MAX_CLASSES-1:0] valid_r;
  logic                   fwd_hit_r;
  logic                   fwd_hit_nxt;
  logic [COUNT_WIDTH-1:0] fwd_data_r;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] wdata;

  assign rd_addr = req_i.addr[AW-1:0];

  // Counter storage
  sic_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (MAX_CLASSES)
  ) u_ram (
    .clk   (clk),
    .we    (s1_inc_r),
    .waddr (s1_addr_r),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Current value: forwarded write, else RAM if the entry is live, else zero
  always_comb begin
    if (fwd_hit_r) begin
      cur = fwd_data_r;
    end else if (valid_r[s1_addr_r]) begin
      cur = rdata;
    end else begin
      cur = '0;
    end
  end

  // Saturating increment
  assign wdata   = (cur == {COUNT_WIDTH{1'b1}}) ? cur : cur + COUNT_WIDTH'(1);
  assign count_o = cur;

  assign fwd_hit_nxt = s1_inc_r && (s1_addr_r == rd_addr) && !clear_i;

  // Second stage, valid bits and forwarding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_inc_r  <= 1'b0;
      valid_r   <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      s1_inc_r  <= req_i.inc;
      fwd_hit_r <= fwd_hit_nxt;
      // clear is younger than the write in flight, so it wins
      if (clear_i) begin
        valid_r <= '0;
      end else if (s1_inc_r) begin
        valid_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= rd_addr;
    fwd_data_r <= wdata;
  end

endmodule
`default_nettype wire

>>> rtl/sic_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sic_out_fifo: result word buffer
// Small register FIFO that decouples the counter pipeline from out_stall.
// ----------------------------------------------------------------------------
module sic_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push_i,
  input  wire sic_pkg::out_word_t            push_word_i,
  input  wire logic                          pop_i,
  output logic                               out_valid_o,
  output sic_pkg::out_word_t                 out_word_o,
  output logic [sic_pkg::OUT_FILL_W-1:0]     fill_o
);

  sic_pkg::out_word_t                 slot_r [sic_pkg::OUT_DEPTH];
  logic [sic_pkg::OUT_PTR_W-1:0]      wr_ptr_r;
  logic [sic_pkg::OUT_PTR_W-1:0]      rd_ptr_r;
  logic [sic_pkg::OUT_FILL_W-1:0]     fill_r;
  logic                               do_pop;

  assign do_pop      = pop_i && (fill_r != '0);
  assign out_valid_o = (fill_r != '0);
  assign out_word_o  = slot_r[rd_ptr_r];
  assign fill_o      = fill_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= wr_ptr_r + sic_pkg::OUT_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + sic_pkg::OUT_PTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   fill_r <= fill_r + sic_pkg::OUT_FILL_W'(1);
        2'b01:   fill_r <= fill_r - sic_pkg::OUT_FILL_W'(1);
        default: fill_r <= fill_r;
      endcase
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push_i) begin
      slot_r[wr_ptr_r] <= push_word_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/segmentation_iou_counter.sv
`default_nettype none
// A result word passes the stage-one register and the output buffer before out_valid offers it.
// Throughput: one input word per cycle while in_stall is low; the counter RAMs do one
// read-modify-write per cycle each, forwarding between back-to-back same-class updates.
// Input stalls only when the 4-entry output buffer cannot absorb the words in flight.
// Reset: synchronous, active low; all counters read as zero at once (valid bits, no
// clearing pass), argmax state cleared, num_classes set to 21.
// ----------------------------------------------------------------------------
// segmentation_iou_counter: per-class TP/FP/FN counters for segmentation
// Running argmax over score channels, then saturating per-class counter
// updates, class reads and global clears.
// ----------------------------------------------------------------------------
module segmentation_iou_counter #(
  parameter int MAX_CLASSES = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire sic_pkg::in_word_t               in_word,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output sic_pkg::out_word_t                   out_word,
  input  wire logic                            cfg_wr_en,
  input  wire logic [sic_pkg::NCLS_W-1:0]      cfg_wr_data
);

  localparam int CW = sic_pkg::CLASS_W;

  sic_pkg::in_word_t                w;
  logic                             accept;
  logic                             is_sample;
  logic                             is_read;
  logic                             is_clear;
  logic                             take;
  logic [CW-1:0]                    pred;
  logic [sic_pkg::NCLS_W-1:0]       lim;
  logic                             ignore;
  logic                             ev_oor;
  logic                             rd_oor;
  logic                             ev;
  logic                             count_ok;
  logic                             hit;
  sic_pkg::bank_req_t               tp_req;
  sic_pkg::bank_req_t               fp_req;
  sic_pkg::bank_req_t               fn_req;
  logic [COUNT_WIDTH-1:0]           tp_cnt;
  logic [COUNT_WIDTH-1:0]           fp_cnt;
  logic [COUNT_WIDTH-1:0]           fn_cnt;
  logic [COUNT_WIDTH+31:0]          tp_ext;
  logic [COUNT_WIDTH+31:0]          fp_ext;
  logic [COUNT_WIDTH+31:0]          fn_ext;
  sic_pkg::out_word_t               push_word;
  logic [sic_pkg::OUT_FILL_W-1:0]   fill;
  logic [sic_pkg::OUT_FILL_W:0]     inflight;
  logic                             pop;

  logic signed [sic_pkg::SCORE_W-1:0] best_score_r;
  logic signed [sic_pkg::SCORE_W-1:0] best_score_nxt;
  logic [CW-1:0]                      best_class_r;
  logic [CW-1:0]                      best_class_nxt;
  logic [sic_pkg::NCLS_W-1:0]         num_classes_r;
  logic                               s1_res_r;
  logic                               s1_read_r;
  logic [CW-1:0]                      s1_class_r;
  logic                               s1_err_r;

  assign w      = in_word;
  assign accept = in_valid && !in_stall;
  assign pop    = out_valid && !out_stall;

  // Request decode
  always_comb begin
    is_sample = 1'b0;
    is_read   = 1'b0;
    is_clear  = 1'b0;
    unique case (w.req_type)
      sic_pkg::REQ_SAMPLE: is_sample = 1'b1;
      sic_pkg::REQ_READ:   is_read   = 1'b1;
      sic_pkg::REQ_CLEAR:  is_clear  = 1'b1;
      default: ;
    endcase
  end

  // Running argmax, first maximum wins
  assign take = (w.channel == '0) || (w.score > best_score_r);
  assign pred = take ? w.channel : best_class_r;
  assign best_score_nxt = (accept && is_sample && take) ? w.score : best_score_r;
  assign best_class_nxt = (accept && is_sample && take) ? w.channel : best_class_r;

  // Class limit and range checks
  assign lim = (num_classes_r < sic_pkg::NCLS_W'(MAX_CLASSES)) ?
               num_classes_r : sic_pkg::NCLS_W'(MAX_CLASSES);
  assign ignore   = (w.label == sic_pkg::IGNORE_LABEL);
  assign ev_oor   = ({1'b0, w.label} >= lim) || ({1'b0, pred} >= lim);
  assign rd_oor   = ({1'b0, w.class_select} >= lim);
  assign ev       = is_sample && w.last_channel;
  assign count_ok = accept && ev && !ignore && !ev_oor;
  assign hit      = (w.label == pred);

  // Bank requests
  assign tp_req.inc  = count_ok && hit;
  assign tp_req.addr = is_read ? w.class_select : w.label;
  assign fn_req.inc  = count_ok && !hit;
  assign fn_req.addr = is_read ? w.class_select : w.label;
  assign fp_req.inc  = count_ok && !hit;
  assign fp_req.addr = is_read ? w.class_select : pred;

  sic_counter_bank #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tp_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear_i (accept && is_clear),
    .req_i   (tp_req),
    .count_o (tp_cnt)
  );

  sic_counter_bank #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fp_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear_i (accept && is_clear),
    .req_i   (fp_req),
    .count_o (fp_cnt)
  );

  sic_counter_bank #(
    .MAX_CLASSES (MAX_CLASSES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fn_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear_i (accept && is_clear),
    .req_i   (fn_req),
    .count_o (fn_cnt)
  );

  // Control state: argmax, config, stage-one result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r  <= '0;
      best_class_r  <= '0;
      num_classes_r <= sic_pkg::NUM_CLASSES_RST;
      s1_res_r      <= 1'b0;
    end else begin
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      if (cfg_wr_en) begin
        num_classes_r <= cfg_wr_data;
      end
      s1_res_r <= accept && (ev || is_read);
    end
  end

  // Stage-one payload
  always_ff @(posedge clk) begin
    s1_read_r  <= is_read;
    s1_class_r <= is_read ? w.class_select : pred;
    s1_err_r   <= is_read ? rd_oor : (!ignore && ev_oor);
  end

  // Result word; counters only on an in-range read, low 32 bits
  assign tp_ext = {32'd0, tp_cnt};
  assign fp_ext = {32'd0, fp_cnt};
  assign fn_ext = {32'd0, fn_cnt};

  always_comb begin
    push_word             = '0;
    push_word.class_index = s1_class_r;
    push_word.range_error = s1_err_r;
    if (s1_read_r && !s1_err_r) begin
      push_word.true_pos  = tp_ext[31:0];
      push_word.false_pos = fp_ext[31:0];
      push_word.false_neg = fn_ext[31:0];
    end
  end

  sic_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (s1_res_r),
    .push_word_i (push_word),
    .pop_i       (pop),
    .out_valid_o (out_valid),
    .out_word_o  (out_word),
    .fill_o      (fill)
  );

  // Stall when the buffer could not hold every word already in flight plus one
  assign inflight = {1'b0, fill} + {{sic_pkg::OUT_FILL_W{1'b0}}, s1_res_r};
  assign in_stall = (inflight >= (sic_pkg::OUT_FILL_W + 1)'(sic_pkg::OUT_DEPTH));

  // Assertions
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (fill == sic_pkg::OUT_FILL_W'(sic_pkg::OUT_DEPTH)) |-> !(s1_res_r && !pop))
    else $error("output buffer overflow");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (fill == sic_pkg::OUT_FILL_W'(sic_pkg::OUT_DEPTH)) |-> in_stall)
    else $error("input not stalled with full output buffer");

  a_res_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_res_r |-> $past(in_valid && !in_stall))
    else $error("result produced without an accepted word");

endmodule
`default_nettype wire

>>> test/iou_checker.sv
// ----------------------------------------------------------------------------
// iou_checker: scoreboard for the segmentation IoU counter
// Watches the input, result and register ports, keeps its own argmax and
// per-class tallies, and compares every result word against the oldest
// predicted word. Hands the error count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
module iou_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  sic_pkg::in_word_t          in_word,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  sic_pkg::out_word_t         out_word,
  input  logic                       cfg_wr_en,
  input  logic [sic_pkg::NCLS_W-1:0] cfg_wr_data,
  output int                         errors,
  output int                         pending
);

  localparam int NUM_SLOTS = 256;

  // Shadow of the block's state
  logic signed [sic_pkg::SCORE_W-1:0] pixel_best_score;
  logic [sic_pkg::CLASS_W-1:0]        pixel_best_class;
  logic [31:0]                        tp_tally [NUM_SLOTS];
  logic [31:0]                        fp_tally [NUM_SLOTS];
  logic [31:0]                        fn_tally [NUM_SLOTS];
  logic [sic_pkg::NCLS_W-1:0]         class_count;

  sic_pkg::out_word_t expected_words [$];

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  task automatic zero_tallies();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tp_tally[i] = '0;
      fp_tally[i] = '0;
      fn_tally[i] = '0;
    end
  endtask

  // Append one predicted word at the tail of the queue
  task automatic queue_expected(input sic_pkg::out_word_t r);
    expected_words.insert(expected_words.size(), r);
  endtask

  // Update the shadow state for one accepted word and queue its result, if any
  task automatic apply_word(input sic_pkg::in_word_t w);
    sic_pkg::out_word_t r;
    int lim;
    r = '0;
    lim = (class_count > 9'd256) ? 256 : int'(class_count);
    case (w.req_type)
      sic_pkg::REQ_SAMPLE: begin
        // strict compare: first maximum keeps the class
        if (w.channel == '0 || w.score > pixel_best_score) begin
          pixel_best_score = w.score;
          pixel_best_class = w.channel;
        end
        if (w.last_channel) begin
          r.class_index = pixel_best_class;
          if (w.label == sic_pkg::IGNORE_LABEL) begin
            // don't-care pixel, nothing counted
          end else if (int'(w.label) >= lim || int'(pixel_best_class) >= lim) begin
            r.range_error = 1'b1;
          end else if (w.label == pixel_best_class) begin
            tp_tally[w.label] = sat_inc(tp_tally[w.label]);
          end else begin
            fn_tally[w.label] = sat_inc(fn_tally[w.label]);
            fp_tally[pixel_best_class] = sat_inc(fp_tally[pixel_best_class]);
          end
          queue_expected(r);
        end
      end
      sic_pkg::REQ_READ: begin
        r.class_index = w.class_select;
        if (int'(w.class_select) >= lim) begin
          r.range_error = 1'b1;
        end else begin
          r.true_pos  = tp_tally[w.class_select];
          r.false_pos = fp_tally[w.class_select];
          r.false_neg = fn_tally[w.class_select];
        end
        queue_expected(r);
      end
      sic_pkg::REQ_CLEAR: zero_tallies();
      default: ;  // unused code, dropped
    endcase
  endtask

  // Compare one result word against the oldest prediction
  task automatic check_word(input sic_pkg::out_word_t got);
    sic_pkg::out_word_t want;
    if (expected_words.size() == 0) begin
      errors++;
      $display({"%0t: unexpected result word: expected none,",
                " got class %0d tp %0d fp %0d fn %0d err %0b"},
               $time, got.class_index, got.true_pos, got.false_pos, got.false_neg,
               got.range_error);
    end else begin
      want = expected_words.pop_front();
      if (got.class_index != want.class_index || got.true_pos != want.true_pos ||
          got.false_pos != want.false_pos || got.false_neg != want.false_neg ||
          got.range_error != want.range_error) begin
        errors++;
        $display({"%0t: result mismatch: expected class %0d tp %0d fp %0d fn %0d err %0b,",
                  " got class %0d tp %0d fp %0d fn %0d err %0b"},
                 $time, want.class_index, want.true_pos, want.false_pos, want.false_neg,
                 want.range_error, got.class_index, got.true_pos, got.false_pos,
                 got.false_neg, got.range_error);
      end
    end
  endtask

  // Sample all ports at the rising edge; a word accepted at the same edge as a
  // register write still sees the old class count
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_best_score = '0;
      pixel_best_class = '0;
      zero_tallies();
      class_count = sic_pkg::NUM_CLASSES_RST;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall)
        check_word(out_word);
      if (in_valid && !in_stall)
        apply_word(in_word);
      if (cfg_wr_en)
        class_count = cfg_wr_data;
    end
    pending = expected_words.size();
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for segmentation_iou_counter
// Resets the block, runs a directed set of words, then random phases with
// different class counts and idle patterns. Results are checked by
// iou_checker; this module only drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  sic_pkg::in_word_t          in_word = '0;
  logic                       out_stall = 1'b0;
  logic                       cfg_wr_en = 1'b0;
  logic [sic_pkg::NCLS_W-1:0] cfg_wr_data = '0;
  logic                       in_stall;
  logic                       out_valid;
  sic_pkg::out_word_t         out_word;
  int                         errors;
  int                         pending;

  int send_pct  = 0;   // chance of an idle cycle before each word
  int stall_pct = 0;   // chance of a receiver stall per cycle
  int lim_now   = 21;  // class limit in force, used to shape stimulus
  int sent      = 0;

  always #10 clk = ~clk;

  segmentation_iou_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  iou_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .pending    (pending)
  );

  // Receiver backpressure
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  function automatic sic_pkg::in_word_t mk_word(input sic_pkg::req_type_t req,
                                                input logic [15:0] score,
                                                input logic [7:0] ch, input logic last,
                                                input logic [7:0] label,
                                                input logic [7:0] sel);
    sic_pkg::in_word_t w;
    w.req_type     = req;
    w.score        = score;
    w.channel      = ch;
    w.last_channel = last;
    w.label        = label;
    w.class_select = sel;
    return w;
  endfunction

  // Scores: often extremes or repeats so that ties come up
  function automatic logic [15:0] pick_score();
    logic [15:0] s;
    case ($urandom_range(7))
      0: s = 16'h8000;
      1: s = 16'h7fff;
      2: s = 16'h0100;
      3: s = 16'hffff;
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  function automatic int top_class();
    if (lim_now < 1) return 0;
    return (lim_now > 256) ? 255 : lim_now - 1;
  endfunction

  // One word through the input handshake, with random idle cycles ahead of it
  task automatic send(input sic_pkg::in_word_t w);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Wait until every predicted word has come out and the pipe is empty
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_cfg(input logic [sic_pkg::NCLS_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lim_now = (v > 9'd256) ? 256 : int'(v);
  endtask

  // A well-formed pixel: channel 0 first, then random channels, label mostly
  // one of the pixel's channels
  task automatic send_pixel();
    logic [7:0] chans [6];
    logic [7:0] label;
    int n;
    int chmax;
    n = $urandom_range(1, 6);
    chmax = ($urandom_range(9) == 0) ? 255 : top_class();
    chans[0] = 8'd0;
    for (int k = 1; k < n; k++)
      chans[k] = 8'($urandom_range(chmax));
    case ($urandom_range(99) / 20)
      0, 1, 2: label = chans[$urandom_range(n - 1)];
      3:       label = 8'($urandom_range(top_class()));
      default: label = ($urandom_range(1) == 0) ? sic_pkg::IGNORE_LABEL : 8'($urandom);
    endcase
    for (int k = 0; k < n; k++)
      send(mk_word(sic_pkg::REQ_SAMPLE, pick_score(), chans[k], k == n - 1, label,
                   8'($urandom)));
  endtask

  task automatic send_read();
    logic [7:0] sel;
    sel = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(top_class()));
    send(mk_word(sic_pkg::REQ_READ, 16'($urandom), 8'($urandom), 1'($urandom),
                 8'($urandom), sel));
  endtask

  // Random phase: mostly pixels and reads, some clears and noise
  task automatic run_phase(input int quota);
    int start;
    bit paused;
    start = sent;
    paused = 0;
    while (sent - start < quota) begin
      case ($urandom_range(99) / 5)
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: send_pixel();
        11, 12, 13, 14: send_read();
        15: send(mk_word(sic_pkg::REQ_CLEAR, 16'($urandom), 8'($urandom), 1'($urandom),
                         8'($urandom), 8'($urandom)));
        16: send(mk_word(sic_pkg::req_type_t'(2'd3), 16'($urandom), 8'($urandom),
                         1'($urandom), 8'($urandom), 8'($urandom)));
        default: send(mk_word(sic_pkg::req_type_t'($urandom_range(3)), pick_score(),
                              8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));
      endcase
      // sender holds off until the block has caught up
      if (!paused && sent - start > quota / 2) begin
        paused = 1;
        drain();
      end
    end
  endtask

  // Class counts per phase, extremes included
  logic [sic_pkg::NCLS_W-1:0] phase_cfg [8] =
    '{9'd1, 9'd256, 9'd0, 9'd2, 9'd511, 9'd21, 9'd300, 9'd7};

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset class count
    send(mk_word(sic_pkg::REQ_READ,   16'h0000, 8'd0,   1'b0, 8'd0,   8'd0));
    // nonzero channel with no pixel start, against the reset best score
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h0005, 8'd3,   1'b1, 8'd3,   8'd0));
    // tie: first maximum wins, so a miss on label 1
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h0064, 8'd0,   1'b0, 8'd1,   8'd0));
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h0064, 8'd1,   1'b1, 8'd1,   8'd0));
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h8000, 8'd0,   1'b0, 8'd2,   8'd0));
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h7fff, 8'd2,   1'b1, 8'd2,   8'd0));
    // ignored label
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'hffff, 8'd0,   1'b1, 8'd255, 8'hff));
    // label beyond the class limit
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h0000, 8'd0,   1'b1, 8'd21,  8'd0));
    // prediction beyond the class limit
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h0000, 8'd0,   1'b0, 8'd0,   8'd0));
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'h7fff, 8'd200, 1'b1, 8'd0,   8'd0));
    send(mk_word(sic_pkg::REQ_SAMPLE, 16'hffff, 8'd255, 1'b1, 8'd254, 8'd0));
    for (int c = 0; c < 4; c++)
      send(mk_word(sic_pkg::REQ_READ, 16'h0000, 8'd0, 1'b0, 8'd0, 8'(c)));
    send(mk_word(sic_pkg::REQ_READ,   16'h0000, 8'd0,   1'b0, 8'd0,   8'd20));
    send(mk_word(sic_pkg::REQ_READ,   16'h0000, 8'd0,   1'b0, 8'd0,   8'd21));
    send(mk_word(sic_pkg::REQ_READ,   16'hffff, 8'hff,  1'b1, 8'hff,  8'd255));
    send(mk_word(sic_pkg::req_type_t'(2'd3), 16'hffff, 8'hff, 1'b1, 8'hff, 8'hff));
    send(mk_word(sic_pkg::REQ_CLEAR,  16'h0000, 8'd0,   1'b0, 8'd0,   8'd0));
    send(mk_word(sic_pkg::REQ_READ,   16'h0000, 8'd0,   1'b0, 8'd0,   8'd3));
    send(mk_word(sic_pkg::REQ_READ,   16'h0000, 8'd0,   1'b0, 8'd0,   8'd1));
    drain();

    // Random phases, cycling through the idle patterns
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 62; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 62; end
        default: begin send_pct = 37; stall_pct = 37; end
      endcase
      write_cfg(phase_cfg[p]);
      run_phase(120);
      drain();
    end

    stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
